[sv/voice_channel_picker_top_defines.svh]
// assertion macros for the voice channel picker
// included by voice_channel_picker_top; no other dependencies
`ifndef VOICE_CHANNEL_PICKER_TOP_DEFINES_SVH
`define VOICE_CHANNEL_PICKER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication checked at every clock while out of reset
`define VCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcp assertion failed");
// next-cycle implication checked at every clock while out of reset
`define VCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcp assertion failed");
`else
`define VCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define VCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/vcp_pkg.sv]
// shared types and constants of the voice channel picker
// used by vcp_voice_ram, vcp_scan_engine and voice_channel_picker_top
package vcp_pkg;

    localparam int ENTITY_W      = 12;
    localparam int CHAN_W        = 4;
    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 3;
    localparam int VOICE_INDEX_W = 4;

    localparam logic [CHAN_W-1:0] ANY_CHANNEL         = 4'hF;
    localparam logic [CHAN_W-1:0] NO_OVERRIDE_CHANNEL = 4'h0;
    localparam logic [TIME_W-1:0] LIFE_LIMIT          = 32'h7fff_ffff;

    localparam logic MODE_ALLOCATE = 1'b0;
    localparam logic MODE_RELEASE  = 1'b1;

    // register index as seen on paddr[2]
    localparam logic REG_LISTENER_IDX = 1'b0;

    typedef struct packed {
        logic [ENTITY_W-1:0] owner;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   end_time;
        logic                active;
    } t_voice;

    typedef struct packed {
        logic                mode;
        logic [ENTITY_W-1:0] entity;
        logic [CHAN_W-1:0]   chan;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   end_time;
        logic [SLOT_W-1:0]   slot;
    } t_request;

    typedef struct packed {
        logic                     found;
        logic [VOICE_INDEX_W-1:0] voice_index;
        logic                     was_active;
    } t_result;

endpackage

[sv/vcp_voice_ram.sv]
// voice table memory: one write port, one registered read port
// depends on vcp_pkg (t_voice); entries never written read as all zero
module vcp_voice_ram #(
    parameter int DEPTH = 8,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output vcp_pkg::t_voice      o_rd_data,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  vcp_pkg::t_voice      i_wr_data
);

    vcp_pkg::t_voice r_mem [DEPTH];
    vcp_pkg::t_voice r_rd_q;
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // written marks stand in for the zero reset of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_q : '0;

endmodule

[sv/vcp_scan_engine.sv]
// sequencer that scans the table for a voice or frees one; writes it back
// depends on vcp_pkg; drives the ports of vcp_voice_ram
module vcp_scan_engine #(
    parameter int DYNAMIC_VOICES = 8,
    parameter int AMBIENT_VOICES = 4,
    localparam int IDX_W = (DYNAMIC_VOICES > 1) ? $clog2(DYNAMIC_VOICES) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  vcp_pkg::t_request               i_req,
    input  logic [vcp_pkg::ENTITY_W-1:0]    i_listener,
    output logic                            o_busy,
    output logic                            o_rd_en,
    output logic [IDX_W-1:0]                o_rd_addr,
    input  vcp_pkg::t_voice                 i_rd_data,
    output logic                            o_wr_en,
    output logic [IDX_W-1:0]                o_wr_addr,
    output vcp_pkg::t_voice                 o_wr_data,
    output logic                            o_done,
    output vcp_pkg::t_result                o_result
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_CLAIM   = 4'b0100,
        S_RELEASE = 4'b1000
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DYNAMIC_VOICES - 1);

    t_state                        r_state, n_state;
    vcp_pkg::t_request             r_req, n_req;
    logic [IDX_W-1:0]              r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]              r_pick, n_pick;
    logic                          r_pick_found, n_pick_found;
    logic                          r_pick_active, n_pick_active;
    logic [vcp_pkg::TIME_W-1:0]    r_best, n_best;
    logic                          r_rel_ok, n_rel_ok;
    logic                          r_done, n_done;
    vcp_pkg::t_result              r_result, n_result;

    logic                          accept;
    logic                          slot_ok;
    logic                          hit;
    logic                          guarded;
    logic [vcp_pkg::TIME_W-1:0]    life;
    logic                          better;
    logic                          last;

    assign accept  = i_start && (r_state == S_IDLE);
    assign slot_ok = (32'(i_req.slot) < 32'(DYNAMIC_VOICES));

    // per-entry checks on the word returned for r_chk_idx
    assign hit = (r_req.chan != vcp_pkg::NO_OVERRIDE_CHANNEL)
              && (i_rd_data.owner == r_req.entity)
              && ((i_rd_data.chan == r_req.chan) || (r_req.chan == vcp_pkg::ANY_CHANNEL));
    assign guarded = (i_rd_data.owner == i_listener) && (r_req.entity != i_listener)
                  && i_rd_data.active;
    assign life   = i_rd_data.end_time - r_req.now;
    assign better = $signed(life) < $signed(r_best);
    assign last   = (r_chk_idx == LAST_IDX);

    // read one entry ahead of the one being checked
    always_comb begin
        o_rd_en   = accept || (r_state == S_SCAN);
        o_rd_addr = r_chk_idx + 1'b1;
        if (r_state == S_IDLE) begin
            o_rd_addr = (i_req.mode == vcp_pkg::MODE_RELEASE) ? IDX_W'(i_req.slot) : '0;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_chk_idx     = r_chk_idx;
        n_pick        = r_pick;
        n_pick_found  = r_pick_found;
        n_pick_active = r_pick_active;
        n_best        = r_best;
        n_rel_ok      = r_rel_ok;
        n_done        = 1'b0;
        n_result      = r_result;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_pick;
        o_wr_data     = '{owner: r_req.entity, chan: r_req.chan,
                          end_time: r_req.end_time, active: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req         = i_req;
                    n_chk_idx     = '0;
                    n_pick_found  = 1'b0;
                    n_pick_active = 1'b0;
                    n_best        = vcp_pkg::LIFE_LIMIT;
                    n_rel_ok      = slot_ok;
                    n_state = (i_req.mode == vcp_pkg::MODE_RELEASE) ? S_RELEASE : S_SCAN;
                end
            end
            S_SCAN: begin
                n_chk_idx = r_chk_idx + 1'b1;
                if (hit) begin
                    n_pick        = r_chk_idx;
                    n_pick_found  = 1'b1;
                    n_pick_active = i_rd_data.active;
                    n_state       = S_CLAIM;
                end else begin
                    if (!guarded && better) begin
                        n_best        = life;
                        n_pick        = r_chk_idx;
                        n_pick_found  = 1'b1;
                        n_pick_active = i_rd_data.active;
                    end
                    if (last) begin
                        n_state = S_CLAIM;
                    end
                end
            end
            S_CLAIM: begin
                o_wr_en  = r_pick_found;
                n_done   = 1'b1;
                n_result.found       = r_pick_found;
                n_result.voice_index = r_pick_found
                    ? vcp_pkg::VOICE_INDEX_W'(AMBIENT_VOICES + 32'(r_pick)) : '0;
                n_result.was_active  = r_pick_found && r_pick_active;
                n_state  = S_IDLE;
            end
            S_RELEASE: begin
                // owner and channel stay, the voice goes idle
                o_wr_en   = r_rel_ok;
                o_wr_addr = IDX_W'(r_req.slot);
                o_wr_data = '{owner: i_rd_data.owner, chan: i_rd_data.chan,
                              end_time: '0, active: 1'b0};
                n_done    = 1'b1;
                n_result.found       = r_rel_ok;
                n_result.voice_index = r_rel_ok
                    ? vcp_pkg::VOICE_INDEX_W'(AMBIENT_VOICES + 32'(r_req.slot)) : '0;
                n_result.was_active  = r_rel_ok && i_rd_data.active;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_chk_idx     <= n_chk_idx;
        r_pick        <= n_pick;
        r_pick_found  <= n_pick_found;
        r_pick_active <= n_pick_active;
        r_best        <= n_best;
        r_rel_ok      <= n_rel_ok;
        r_result      <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[sv/voice_channel_picker_top.sv]
// top level of the voice channel picker: apb register, scan engine, voice table
// depends on vcp_pkg, vcp_voice_ram, vcp_scan_engine, voice_channel_picker_top_defines.svh
//
// usage
//   command channel: a word is taken at a clock edge with start high and busy low.
//   i_mode 0 allocates a voice for i_entity / i_entity_channel ending at
//   i_end_time; i_mode 1 releases dynamic voice i_slot.
//   result channel: o_done is high for one cycle with o_found, o_voice_index
//   and o_was_active; every command gives exactly one result word.
//   the receiver cannot stall; o_done drops after that cycle, the result bits hold.
//   an allocate reads the table through the single read port, one
//   entry a cycle, until an entry is overridden or the last entry is checked,
//   then writes back the picked voice, if any; the result word is registered
//   from the claim state. a release does one read, when the command is taken,
//   and one write of that slot for a slot below DYNAMIC_VOICES.
//   busy stays high until the result cycle, so the next command can be
//   taken in the cycle the result shows, and table accesses never overlap.
//   apb register 0 (byte address 0) holds the listener entity.
//   reset clears the listener register and marks every table entry unwritten,
//   which reads as zero; no clearing pass is needed.
module voice_channel_picker_top #(
    parameter int DYNAMIC_VOICES = 8,
    parameter int AMBIENT_VOICES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic [vcp_pkg::ENTITY_W-1:0]         i_entity,
    input  logic signed [vcp_pkg::CHAN_W-1:0]    i_entity_channel,
    input  logic [vcp_pkg::TIME_W-1:0]           i_now,
    input  logic [vcp_pkg::TIME_W-1:0]           i_end_time,
    input  logic [vcp_pkg::SLOT_W-1:0]           i_slot,
    output logic                                 o_done,
    output logic                                 o_found,
    output logic [vcp_pkg::VOICE_INDEX_W-1:0]    o_voice_index,
    output logic                                 o_was_active
);

    `include "voice_channel_picker_top_defines.svh"

    localparam int IDX_W = (DYNAMIC_VOICES > 1) ? $clog2(DYNAMIC_VOICES) : 1;

    logic [vcp_pkg::ENTITY_W-1:0] r_listener;
    logic                         reg_sel;
    logic                         reg_wr;
    vcp_pkg::t_request            req;
    vcp_pkg::t_result             result;
    vcp_pkg::t_voice              rd_data;
    vcp_pkg::t_voice              wr_data;
    logic                         rd_en;
    logic                         wr_en;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             wr_addr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == vcp_pkg::REG_LISTENER_IDX);
    assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? {20'b0, r_listener} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listener <= '0;
        end else if (reg_wr) begin
            r_listener <= pwdata[vcp_pkg::ENTITY_W-1:0];
        end
    end

    assign req = '{mode: i_mode, entity: i_entity, chan: $unsigned(i_entity_channel),
                   now: i_now, end_time: i_end_time, slot: i_slot};

    vcp_scan_engine #(
        .DYNAMIC_VOICES (DYNAMIC_VOICES),
        .AMBIENT_VOICES (AMBIENT_VOICES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (req),
        .i_listener (r_listener),
        .o_busy     (busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_done     (o_done),
        .o_result   (result)
    );

    vcp_voice_ram #(
        .DEPTH (DYNAMIC_VOICES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign o_found       = result.found;
    assign o_voice_index = result.voice_index;
    assign o_was_active  = result.was_active;

    // a taken command keeps the engine busy in the next cycle
    `VCP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result only follows a busy cycle and frees the engine
    `VCP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !busy && $past(busy))
    // table is never written while a new command could be taken
    `VCP_ASSERT_NOW(a_wr_busy, i_clk, i_rst_n, wr_en, busy)
    // a miss reports no voice and no cut
    `VCP_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_done && !o_found,
        (o_voice_index == '0) && !o_was_active)

endmodule
